// File: design/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg: shared definitions for the sync correlator and deframer
// Register indexes, reset values, result layout, PN9 and CRC-16 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

    localparam int FRAME_BYTES_DEF = 74;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int THRESH_W   = 6;
    localparam int PATTERN_W  = 32;
    localparam int DIST_W     = 6;
    localparam int IDX_W      = 7;
    localparam int TDATA_W    = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_THRESHOLD = 1'b0,
        CFG_SYNC_PATTERN   = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        KIND_SYNC = 1'b0,
        KIND_BYTE = 1'b1
    } t_kind;

    localparam logic [THRESH_W-1:0]  SYNC_THRESHOLD_RST = 6'd4;
    localparam logic [PATTERN_W-1:0] SYNC_PATTERN_RST   = 32'h930B_51DE;
    localparam logic [8:0]           PN9_SEED           = 9'h1FF;
    localparam logic [15:0]          CRC_POLY           = 16'h8005;
    localparam logic [15:0]          CRC_INIT           = 16'hFFFF;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic             last;
        logic             crc_ok;
        logic             frame_inverted;
    } t_result;

    typedef struct packed {
        logic [8:0] next_state;
        logic [7:0] mask;
    } t_pn9_step;

    // Eight PN9 steps: output bit 0 first, feedback bit5 ^ bit0 into bit 8
    function automatic t_pn9_step pn9_step8(input logic [8:0] state);
        t_pn9_step  r;
        logic [8:0] s;
        logic       fb;
        s = state;
        r.mask = '0;
        for (int b = 0; b < 8; b++) begin
            r.mask[b] = s[0];
            fb = s[5] ^ s[0];
            s = {fb, s[8:1]};
        end
        r.next_state = s;
        return r;
    endfunction

    // CRC-16, MSB first, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [DIST_W-1:0] popcount32(input logic [31:0] v);
        logic [DIST_W-1:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            n = n + DIST_W'(v[i]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: design/sync_correlate_deframe_pn9_crc16_core.sv
// ----------------------------------------------------------------------------
// sync_correlate_deframe_pn9_crc16_core: sync correlator and frame deframer
// Sync search, frame gathering, PN9 descrambling and CRC-16 check.
// ----------------------------------------------------------------------------
// One hard-decision bit is taken per transaction, one every clock cycle at
// full rate. Each bit is handled in the cycle it is accepted: correlation
// against the sync word and its complement, byte assembly, PN9 and CRC-16
// byte updates are all combinational logic, and any result is registered.
// Results pass through a two-entry output buffer, so the input keeps
// flowing while one result waits; the input stalls only when both entries
// are held by back-pressure. A sync event is emitted on a match, then
// FRAME_BYTES descrambled bytes, the last carrying the CRC verdict.
`default_nettype none

module sync_correlate_deframe_pn9_crc16_core #(
    parameter int FRAME_BYTES = scd_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [scd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [scd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [0] data_bit
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] data_byte, [14:8] byte_index, [15] crc_ok, [16] frame_inverted
    output logic [scd_pkg::TDATA_W-1:0]         m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser   // [0] kind
);
    import scd_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] CRC_HI_IDX = IDX_W'(FRAME_BYTES - 2);

    logic [THRESH_W-1:0]  r_threshold;
    logic [PATTERN_W-1:0] r_pattern;

    logic [31:0]      r_history,  n_history;
    logic             r_in_frame, n_in_frame;
    logic [7:0]       r_assembly, n_assembly;
    logic [2:0]       r_bits,     n_bits;
    logic             r_inverted, n_inverted;
    logic [8:0]       r_scr,      n_scr;
    logic [15:0]      r_crc,      n_crc;
    logic [IDX_W-1:0] r_byte_cnt, n_byte_cnt;
    logic [7:0]       r_crc_hi,   n_crc_hi;

    t_result r_out,  r_skid;
    logic    r_out_valid, r_skid_valid;

    logic              accept;
    logic              bit_in;
    logic [31:0]       hist_shift;
    logic [DIST_W-1:0] dist_true;
    logic [DIST_W-1:0] dist_inv;
    logic              match_true;
    logic              match_inv;
    t_pn9_step         pn9;
    logic [7:0]        byte_val;
    logic              is_last;
    logic              res_valid;
    t_result           res;
    logic              out_free;

    assign accept     = s_axis_tvalid && s_axis_tready;
    assign bit_in     = s_axis_tdata[0];
    assign hist_shift = {r_history[30:0], bit_in};
    assign dist_true  = popcount32(hist_shift ^ r_pattern);
    assign dist_inv   = popcount32(hist_shift ^ ~r_pattern);
    assign match_true = dist_true <= r_threshold;
    assign match_inv  = dist_inv <= r_threshold;
    assign pn9        = pn9_step8(r_scr);
    assign byte_val   = {r_assembly[6:0], bit_in} ^ {8{r_inverted}} ^ pn9.mask;
    assign is_last    = r_byte_cnt == LAST_IDX;

    always_comb begin
        n_history  = r_history;
        n_in_frame = r_in_frame;
        n_assembly = r_assembly;
        n_bits     = r_bits;
        n_inverted = r_inverted;
        n_scr      = r_scr;
        n_crc      = r_crc;
        n_byte_cnt = r_byte_cnt;
        n_crc_hi   = r_crc_hi;
        res_valid  = 1'b0;
        res        = '0;
        if (accept) begin
            n_history = hist_shift;
            if (r_in_frame) begin
                n_assembly = {r_assembly[6:0], bit_in};
                n_bits     = r_bits + 3'd1;
                if (r_bits == 3'd7) begin
                    n_scr = pn9.next_state;
                    if (r_byte_cnt < CRC_HI_IDX) begin
                        n_crc = crc16_byte(r_crc, byte_val);
                    end else if (r_byte_cnt == CRC_HI_IDX) begin
                        n_crc_hi = byte_val;
                    end
                    res_valid          = 1'b1;
                    res.kind           = KIND_BYTE;
                    res.data_byte      = byte_val;
                    res.byte_index     = r_byte_cnt;
                    res.last           = is_last;
                    res.crc_ok         = is_last && (r_crc == {r_crc_hi, byte_val});
                    res.frame_inverted = r_inverted;
                    n_byte_cnt         = r_byte_cnt + IDX_W'(1);
                    if (is_last) begin
                        n_in_frame = 1'b0;
                    end
                end
            end else if (match_true || match_inv) begin
                n_in_frame = 1'b1;
                n_history  = '0;
                n_inverted = !match_true;
                n_assembly = '0;
                n_bits     = '0;
                n_scr      = PN9_SEED;
                n_crc      = CRC_INIT;
                n_byte_cnt = '0;
                n_crc_hi   = '0;
                res_valid          = 1'b1;
                res.kind           = KIND_SYNC;
                res.frame_inverted = !match_true;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= SYNC_THRESHOLD_RST;
            r_pattern   <= SYNC_PATTERN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_THRESHOLD: r_threshold <= i_cfg_data[THRESH_W-1:0];
                CFG_SYNC_PATTERN:   r_pattern   <= i_cfg_data[PATTERN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history  <= '0;
            r_in_frame <= 1'b0;
            r_assembly <= '0;
            r_bits     <= '0;
            r_inverted <= 1'b0;
            r_scr      <= PN9_SEED;
            r_crc      <= CRC_INIT;
            r_byte_cnt <= '0;
            r_crc_hi   <= '0;
        end else begin
            r_history  <= n_history;
            r_in_frame <= n_in_frame;
            r_assembly <= n_assembly;
            r_bits     <= n_bits;
            r_inverted <= n_inverted;
            r_scr      <= n_scr;
            r_crc      <= n_crc;
            r_byte_cnt <= n_byte_cnt;
            r_crc_hi   <= n_crc_hi;
        end
    end

    // output register plus skid entry
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.frame_inverted, r_out.crc_ok,
                            r_out.byte_index, r_out.data_byte};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.kind;

endmodule

`default_nettype wire
